### hw/rtl/two_class_round_robin_orderer_top_defines.svh
// Assertion macros for the two-class round-robin orderer.
// Included by the top level; no other dependencies.
`ifndef TWO_CLASS_ROUND_ROBIN_ORDERER_TOP_DEFINES_SVH
`define TWO_CLASS_ROUND_ROBIN_ORDERER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define TCRRO_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("tcrro assertion failed");
// Check that cons holds in the cycle after ante.
`define TCRRO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("tcrro assertion failed");
`else
`define TCRRO_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define TCRRO_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hw/rtl/tcrro_pkg.sv
// Shared types, constants and helper functions of the round-robin orderer.
// No dependencies.
`default_nettype none

package tcrro_pkg;

	localparam int MAX_REQUESTERS = 16;
	localparam int REQ_W          = MAX_REQUESTERS;
	localparam int IDX_W          = $clog2(MAX_REQUESTERS);
	localparam int CNT_W          = IDX_W + 1;
	localparam int ADDR_W         = 3;
	localparam int DATA_W         = 32;

	// Register index of requester_count
	localparam logic [0:0] REG_REQUESTER_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] COUNT_RESET   = CNT_W'(MAX_REQUESTERS);

	// One batch as it sits in the queue
	typedef struct packed {
		logic [REQ_W-1:0] ready;
		logic [REQ_W-1:0] eof;
	} tcrro_entry_t;

	// Scheduler state visible to the top level
	typedef struct packed {
		logic [REQ_W-1:0] open_mask;
		logic [REQ_W-1:0] served_now;
	} tcrro_status_t;

	// Bits of requesters below the active count
	function automatic logic [REQ_W-1:0] count_mask(input logic [CNT_W-1:0] n);
		logic [REQ_W-1:0] m;
		for (int i = 0; i < REQ_W; i++) begin
			m[i] = (CNT_W'(i) < n);
		end
		return m;
	endfunction

	// First set bit at or above s, else lowest set bit
	function automatic logic [IDX_W-1:0] rr_pick(input logic [REQ_W-1:0] m,
			input logic [IDX_W-1:0] s);
		logic [REQ_W-1:0] hi;
		logic [IDX_W-1:0] lo_i;
		logic [IDX_W-1:0] hi_i;
		hi   = m & ({REQ_W{1'b1}} << s);
		lo_i = '0;
		hi_i = '0;
		for (int i = REQ_W - 1; i >= 0; i--) begin
			if (m[i]) lo_i = IDX_W'(i);
			if (hi[i]) hi_i = IDX_W'(i);
		end
		return (hi != '0) ? hi_i : lo_i;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tcrro_front.sv
// Front end: accepts batches, drops mask bits at or above the count, queues them.
// Depends on tcrro_pkg.
`default_nettype none

module tcrro_front
	import tcrro_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [CNT_W-1:0]    eff_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [REQ_W-1:0]    ready_mask,
	input  wire logic [REQ_W-1:0]    eof_mask,
	output logic                     q_valid,
	output tcrro_entry_t             q_entry,
	input  wire logic                q_pop
);

	tcrro_entry_t     ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;
	logic [REQ_W-1:0] live;

	// Classify: keep only requesters in use, eof only where ready
	assign live     = count_mask(eff_n) & ready_mask;
	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_entry  = ent_q[rd_ptr_q];

	// Store incoming item
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q].ready <= live;
			ent_q[wr_ptr_q].eof   <= live & eof_mask;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tcrro_back.sv
// Back end: orders one batch at a time into grants, one grant per cycle while
// the output is not stalled. Holds open, served and rotation state. Depends on tcrro_pkg.
`default_nettype none

module tcrro_back
	import tcrro_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [CNT_W-1:0]    eff_n,
	input  wire logic                q_valid,
	input  wire tcrro_entry_t        q_entry,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [IDX_W-1:0]         grant_index,
	output logic                     closed_now,
	output logic                     last_in_batch,
	output tcrro_status_t            status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SCAN
	} state_t;

	state_t           state_q;
	logic [REQ_W-1:0] ready_q;
	logic [REQ_W-1:0] eof_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] rot_q;
	logic [REQ_W-1:0] pend0_q;
	logic [REQ_W-1:0] pend1_q;
	logic [REQ_W-1:0] served_q;
	logic [REQ_W-1:0] served_last_q;
	logic [REQ_W-1:0] open_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] grant_q;
	logic             closed_q;
	logic             last_q;

	logic [REQ_W-1:0] active;
	logic [IDX_W-1:0] pick;
	logic [REQ_W-1:0] pick_bit;
	logic             out_free;
	logic             emit;
	logic [CNT_W-1:0] start_inc;

	// Unserved class first, then recently served class
	assign active    = (pend0_q != '0) ? pend0_q : pend1_q;
	assign pick      = rr_pick(active, start_q);
	assign pick_bit  = REQ_W'(1) << pick;
	assign out_free  = !out_valid_q || !out_stall;
	assign emit      = (state_q == ST_SCAN) && (active != '0) && out_free;
	assign start_inc = {1'b0, start_q} + CNT_W'(1);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	assign out_valid         = out_valid_q;
	assign grant_index       = grant_q;
	assign closed_now        = closed_q;
	assign last_in_batch     = last_q;
	assign status.open_mask  = open_q;
	assign status.served_now = served_q;

	// Sequencer with output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ready_q       <= '0;
			eof_q         <= '0;
			start_q       <= '0;
			rot_q         <= '0;
			pend0_q       <= '0;
			pend1_q       <= '0;
			served_q      <= '0;
			served_last_q <= '0;
			open_q        <= '1;
			out_valid_q   <= 1'b0;
			grant_q       <= '0;
			closed_q      <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			// Refill or drop output once taken
			if (out_free) out_valid_q <= emit;

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						ready_q <= q_entry.ready;
						eof_q   <= q_entry.eof;
						start_q <= rot_q;
						state_q <= ST_REDUCE;
					end
				end
				// Bring start below the count, then snapshot both classes
				ST_REDUCE: begin
					if ({1'b0, start_q} >= eff_n) begin
						start_q <= start_q - eff_n[IDX_W-1:0];
					end else begin
						pend0_q  <= ready_q & open_q & ~served_last_q;
						pend1_q  <= ready_q & open_q & served_last_q;
						served_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (active == '0) begin
						served_last_q <= served_q;
						rot_q         <= (start_inc == eff_n) ? '0 : start_inc[IDX_W-1:0];
						state_q       <= ST_IDLE;
					end else if (out_free) begin
						grant_q     <= pick;
						closed_q    <= eof_q[pick];
						last_q      <= (((pend0_q | pend1_q) & ~pick_bit) == '0);
						pend0_q     <= pend0_q & ~pick_bit;
						pend1_q     <= pend1_q & ~pick_bit;
						if (eof_q[pick]) begin
							open_q[pick] <= 1'b0;
						end else begin
							served_q[pick] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/two_class_round_robin_orderer_top.sv
// Path: an accepted batch is queued in the front end, then popped into the back end's
// batch registers; the start pointer is brought below the count before the first grant.
// Throughput: per batch, one grant per cycle while the output is not stalled, plus
// setup and wrap-up in the back-end sequencer; a 2-entry queue lets the front keep accepting.
// Reset: open mask all ones, served mask clear, rotation start 0, count 16.
`default_nettype none
`include "two_class_round_robin_orderer_top_defines.svh"

module two_class_round_robin_orderer_top
	import tcrro_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [REQ_W-1:0]  ready_mask,
	input  wire logic [REQ_W-1:0]  eof_mask,
	// output channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [IDX_W-1:0]       grant_index,
	output logic                   closed_now,
	output logic                   last_in_batch
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] eff_n;
	logic             cfg_wr;
	logic             q_valid;
	logic             q_pop;
	tcrro_entry_t     q_entry;
	tcrro_status_t    status;

	// Register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_REQUESTER_COUNT);
	assign prdata = (paddr[2:2] == REG_REQUESTER_COUNT) ?
		{{(DATA_W-CNT_W){1'b0}}, count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_wr) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	// Clamp count into 1..MAX_REQUESTERS
	always_comb begin
		priority if (count_q == '0) begin
			eff_n = CNT_W'(1);
		end else if (count_q > CNT_W'(MAX_REQUESTERS)) begin
			eff_n = CNT_W'(MAX_REQUESTERS);
		end else begin
			eff_n = count_q;
		end
	end

	tcrro_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.eff_n      (eff_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ready_mask (ready_mask),
		.eof_mask   (eof_mask),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_pop      (q_pop)
	);

	tcrro_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.eff_n         (eff_n),
		.q_valid       (q_valid),
		.q_entry       (q_entry),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.grant_index   (grant_index),
		.closed_now    (closed_now),
		.last_in_batch (last_in_batch),
		.status        (status)
	);

	// A closing grant has already cleared its open bit
	`TCRRO_ASSERT_SAME(a_closed_not_open, clk, arst_n, out_valid && closed_now, !status.open_mask[grant_index])
	// Requesters served in this batch are still open
	`TCRRO_ASSERT_SAME(a_served_open, clk, arst_n, 1'b1, (status.served_now & ~status.open_mask) == '0)
	// A closed requester never reopens
	`TCRRO_ASSERT_NEXT(a_no_reopen, clk, arst_n, 1'b1, (status.open_mask & ~$past(status.open_mask)) == '0)

endmodule

`default_nettype wire
